FILE: hdl/pds_pkg.sv
// package for the process dispatch scheduler
// types and constants shared by all modules; no dependencies
package pds_pkg;

    localparam int NPROC_DEF = 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [2:0] K_RUN  = 3'd0;
    localparam logic [2:0] K_IDLE = 3'd1;
    localparam logic [2:0] K_DONE = 3'd2;
    localparam logic [2:0] K_LDOK = 3'd3;
    localparam logic [2:0] K_FULL = 3'd4;

    localparam logic [2:0] M_RR   = 3'd0;
    localparam logic [2:0] M_PRIO = 3'd1;
    localparam logic [2:0] M_SJF  = 3'd2;
    localparam logic [2:0] M_PPRI = 3'd3;
    localparam logic [2:0] M_SRTF = 3'd4;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  job_id;
        logic [15:0] arrival;
        logic [11:0] burst;
        logic [7:0]  prio;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  run_id;
        logic [15:0] start_time;
        logic [11:0] run_length;
        logic        job_done;
        logic [15:0] turnaround;
        logic [15:0] waiting;
    } t_out_word;

    typedef struct packed {
        logic [15:0] arrival;
        logic [11:0] burst;
        logic [11:0] remaining;
        logic [7:0]  prio;
        logic [7:0]  id;
        logic        finished;
    } t_entry;

endpackage

FILE: hdl/pds_table.sv
// job table memory, one read port and one write port, registered read
// depends on pds_pkg
module pds_table
    import pds_pkg::*;
#(
    parameter int NPROC = NPROC_DEF,
    parameter int AW = (NPROC > 1) ? $clog2(NPROC) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);
    t_entry r_mem [NPROC];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/process_dispatch_scheduler_core.sv
// process dispatch scheduler top level: control sequencer over the job table
// depends on pds_pkg and pds_table
// A load that is accepted searches for the insert slot, then shifts entries up one
// at a time through the table's one read port and writes the new job; in modes
// 3 and 4 the job is appended. A load into a full table only reports it full. A
// dispatch makes one pass over the table to pick the job, then the chosen entry is
// read again, updated and written back. Round robin may take a second pass
// when its sweep wraps. A clear is done in the idle state. One word is handled
// at a time; a new word is taken only once the previous result has been accepted
// or is accepted in that same cycle.
module process_dispatch_scheduler_core
    import pds_pkg::*;
#(
    parameter int NPROC = NPROC_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    localparam int AW = (NPROC > 1) ? $clog2(NPROC) : 1;
    localparam int CW = $clog2(NPROC + 1);
    localparam logic [CW-1:0] FULL = CW'(NPROC);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_LSCH = 8'b00000010,
        S_LSHF = 8'b00000100,
        S_LWR  = 8'b00001000,
        S_SCAN = 8'b00010000,
        S_PICK = 8'b00100000,
        S_UPD  = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_st;
    t_in_word r_in;
    logic [2:0] r_mode;
    logic [11:0] r_quant;
    logic [CW-1:0] r_cnt;
    logic [15:0] r_now;
    logic [AW-1:0] r_sptr;
    logic r_sran;
    logic r_rv;
    logic [AW-1:0] r_ridx;

    logic [CW-1:0] r_ix;       // index being issued
    logic r_rdv;               // read data valid this cycle
    logic [AW-1:0] r_rdi;      // index of read data
    logic r_pend, r_bv, r_pass2;
    logic [AW-1:0] r_best;
    logic [11:0] r_bkey;
    logic [7:0] r_rprio;
    logic r_rok;
    logic [CW-1:0] r_pos;

    logic r_ob_v;
    t_out_word r_ob;
    t_out_word n_ob;

    logic we;
    logic [AW-1:0] waddr, raddr;
    t_entry wdata, rd;

    pds_table #(.NPROC(NPROC), .AW(AW)) u_tbl (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd)
    );

    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_stall = (r_st != S_IDLE) || (r_ob_v && i_stall);
    assign o_valid = r_ob_v;
    assign o_data = r_ob;

    wire accept = i_valid && !o_stall;
    wire sorted = (r_mode != M_PPRI) && (r_mode != M_SRTF);
    wire scan_last = (r_ix == r_cnt);
    wire elig = !rd.finished && (rd.arrival <= r_now);
    wire rr_mode = !(r_mode == M_PRIO || r_mode == M_SJF
                    || r_mode == M_PPRI || r_mode == M_SRTF);
    wire [11:0] q = (r_quant == 12'd0) ? 12'd1 : r_quant;
    // preemptive priority keeps the runner unless a strictly better job waits
    wire keep_run = (r_mode == M_PPRI) && r_rv && r_rok
                    && !(r_bv && r_bkey[7:0] < r_rprio);
    wire [AW-1:0] sel_idx = keep_run ? r_ridx : r_best;
    logic [11:0] key;

    always_comb begin
        case (r_mode)
            M_PRIO, M_PPRI: key = {4'd0, rd.prio};
            M_SJF: key = rd.burst;
            default: key = rd.remaining;
        endcase
    end

    // result of run on re-read entry
    logic [11:0] len, rem_n;
    logic [15:0] now_n, ta;
    always_comb begin
        if (rr_mode) begin
            len = (rd.remaining < q) ? rd.remaining : q;
        end else if (r_mode == M_PPRI || r_mode == M_SRTF) begin
            len = 12'd1;
        end else begin
            len = rd.remaining;
        end
        rem_n = rd.remaining - len;
        now_n = r_now + {4'd0, len};
        ta = now_n - rd.arrival;
    end

    always_comb begin
        n_ob = '0;
        if (r_st == S_OUT) begin
            n_ob.kind = (r_pos == FULL) ? K_FULL : K_LDOK;
            n_ob.run_id = r_in.job_id;
        end else if (!r_pend) begin
            n_ob.kind = K_DONE;
            n_ob.start_time = r_now;
        end else if (!r_bv) begin
            n_ob.kind = K_IDLE;
            n_ob.start_time = r_now;
            n_ob.run_length = 12'd1;
        end else begin
            n_ob.kind = K_RUN;
            n_ob.run_id = rd.id;
            n_ob.start_time = r_now;
            n_ob.run_length = len;
            if (rem_n == 12'd0) begin
                n_ob.job_done = 1'b1;
                n_ob.turnaround = ta;
                n_ob.waiting = ta - {4'd0, rd.burst};
            end
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = r_rdi;
        wdata = rd;
        raddr = r_ix[AW-1:0];
        case (r_st)
            S_LSHF: begin
                we = r_rdv;
                waddr = AW'(r_rdi + 1'b1);
                raddr = AW'(r_ix - 1'b1);
            end
            S_LWR: begin
                we = 1'b1;
                waddr = r_pos[AW-1:0];
                wdata.arrival = r_in.arrival;
                wdata.burst = (r_in.burst == 12'd0) ? 12'd1 : r_in.burst;
                wdata.remaining = wdata.burst;
                wdata.prio = r_in.prio;
                wdata.id = r_in.job_id;
                wdata.finished = 1'b0;
            end
            S_PICK: raddr = sel_idx;
            S_UPD: begin
                we = r_pend && r_bv;
                waddr = r_best;
                wdata.remaining = rem_n;
                wdata.finished = (rem_n == 12'd0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_mode <= M_RR;
            r_quant <= 12'd4;
            r_cnt <= '0;
            r_now <= '0;
            r_sptr <= '0;
            r_sran <= 1'b0;
            r_rv <= 1'b0;
            r_ridx <= '0;
            r_ob_v <= 1'b0;
            r_rdv <= 1'b0;
        end else begin
            if (r_st == S_UPD || r_st == S_OUT) begin
                r_ob_v <= 1'b1;
            end else if (r_ob_v && !i_stall) begin
                r_ob_v <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_MODE) r_mode <= i_cfg_data[2:0];
                else r_quant <= i_cfg_data;
            end
            case (r_st)
                S_IDLE: begin
                    r_rdv <= 1'b0;
                    if (accept) begin
                        r_in <= i_data;
                        r_ix <= (i_data.op == OP_STEP && rr_mode) ? CW'(r_sptr) : '0;
                        r_pend <= 1'b0;
                        r_bv <= 1'b0;
                        r_pass2 <= 1'b0;
                        r_rok <= 1'b0;
                        if (i_data.op == OP_CLEAR) begin
                            r_cnt <= '0;
                            r_now <= '0;
                            r_sptr <= '0;
                            r_sran <= 1'b0;
                            r_rv <= 1'b0;
                            r_ridx <= '0;
                        end else if (i_data.op == OP_LOAD) begin
                            r_pos <= r_cnt;
                            r_st <= (r_cnt == FULL) ? S_OUT : S_LSCH;
                        end else if (i_data.op == OP_STEP) begin
                            r_st <= S_SCAN;
                        end
                    end
                end
                S_LSCH: begin
                    r_rdi <= r_ix[AW-1:0];
                    if (r_rdv && (rd.arrival > r_in.arrival || (rd.arrival == r_in.arrival
                            && rd.prio > r_in.prio))) begin
                        r_pos <= CW'(r_rdi);
                        r_ix <= r_cnt;
                        r_rdv <= 1'b0;
                        r_st <= S_LSHF;
                    end else if (!r_rdv && (scan_last || !sorted)) begin
                        r_rdv <= 1'b0;
                        r_st <= S_LSHF;
                    end else begin
                        r_rdv <= !scan_last && sorted;
                        if (!scan_last && sorted) r_ix <= r_ix + 1'b1;
                    end
                end
                S_LSHF: begin
                    // read entry ix-1, write it at ix next cycle
                    if (r_ix > r_pos) begin
                        r_rdv <= 1'b1;
                        r_rdi <= AW'(r_ix - 1'b1);
                        r_ix <= r_ix - 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) r_st <= S_LWR;
                    end
                end
                S_LWR: begin
                    if (r_rv && CW'(r_ridx) >= r_pos && CW'(r_ridx) < r_cnt)
                        r_ridx <= r_ridx + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    r_st <= S_OUT;
                end
                S_SCAN: begin
                    r_rdv <= !scan_last;
                    r_rdi <= r_ix[AW-1:0];
                    if (!scan_last) r_ix <= r_ix + 1'b1;
                    if (r_rdv) begin
                        if (!rd.finished) r_pend <= 1'b1;
                        if (r_rv && r_rdi == r_ridx) begin
                            r_rok <= !rd.finished;
                            r_rprio <= rd.prio;
                        end
                        if (elig) begin
                            if (rr_mode) begin
                                if (!r_bv) begin
                                    r_bv <= 1'b1;
                                    r_best <= r_rdi;
                                end
                            end else if (!r_bv || key < r_bkey) begin
                                r_bv <= 1'b1;
                                r_best <= r_rdi;
                                r_bkey <= key;
                            end
                        end
                    end
                    if (!r_rdv && scan_last) begin
                        if (rr_mode && !r_bv && r_sran && !r_pass2 && r_sptr != '0) begin
                            r_pass2 <= 1'b1;
                            r_ix <= '0;
                        end else begin
                            r_st <= S_PICK;
                        end
                    end
                end
                S_PICK: begin
                    r_best <= sel_idx;
                    if (r_mode == M_PPRI && r_rv && r_rok) r_bv <= 1'b1;
                    r_st <= S_UPD;
                end
                S_UPD: begin
                    r_ob <= n_ob;
                    r_st <= S_IDLE;
                    if (r_mode == M_PPRI && r_pend && r_bv) begin
                        r_rv <= (rem_n != 12'd0);
                        r_ridx <= r_best;
                    end else if (r_mode == M_PPRI && r_rv && !r_rok) begin
                        r_rv <= 1'b0;
                    end
                    if (r_pend && !r_bv) begin
                        r_now <= r_now + 16'd1;
                        if (rr_mode) begin
                            r_sptr <= '0;
                            r_sran <= 1'b0;
                        end
                    end else if (r_pend) begin
                        r_now <= now_n;
                        if (rr_mode) begin
                            if (CW'(r_best) + 1'b1 >= r_cnt) begin
                                r_sptr <= '0;
                                r_sran <= 1'b0;
                            end else begin
                                r_sptr <= r_best + 1'b1;
                                r_sran <= 1'b1;
                            end
                        end
                    end
                end
                S_OUT: begin
                    r_ob <= n_ob;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: dv/tb.sv
// testbench for process_dispatch_scheduler_core: random and directed job loads,
// dispatch steps and clears checked against an in-bench scheduler model
// depends on pds_pkg and the scheduler rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pds_pkg::*;

    localparam int NJOB = 16;
    localparam int IW = $bits(t_in_word);

    class sched_board;
        logic [15:0] arr_q[NJOB];
        logic [11:0] bur_q[NJOB];
        logic [11:0] rem_q[NJOB];
        logic [7:0]  pri_q[NJOB];
        logic [7:0]  id_q[NJOB];
        bit          fin_q[NJOB];
        int          count;
        logic [15:0] clock_now;
        int          sweep;
        bit          swept;
        bit          run_ok;
        int          run_at;
        logic [2:0]  mode;
        logic [11:0] quant;
        t_out_word   pending[$];
        int          errors;

        function void clear_all();
            count = 0;
            clock_now = 0;
            sweep = 0;
            swept = 0;
            run_ok = 0;
            run_at = 0;
        endfunction

        function bit ready_at(int i);
            return i < count && !fin_q[i] && arr_q[i] <= clock_now;
        endfunction

        function t_out_word pack_word(logic [2:0] k, logic [7:0] id, logic [15:0] st,
                                      logic [11:0] len, bit dn, logic [15:0] ta,
                                      logic [15:0] wt);
            t_out_word w;
            w.kind = k;
            w.run_id = id;
            w.start_time = st;
            w.run_length = len;
            w.job_done = dn;
            w.turnaround = ta;
            w.waiting = wt;
            return w;
        endfunction

        function t_out_word run_for(int i, logic [11:0] len);
            logic [15:0] st;
            logic [15:0] ta;
            logic [15:0] wt;
            bit dn;
            st = clock_now;
            ta = 0;
            wt = 0;
            dn = 0;
            clock_now = clock_now + 16'(len);
            rem_q[i] = rem_q[i] - len;
            if (rem_q[i] == 0) begin
                fin_q[i] = 1;
                dn = 1;
                ta = clock_now - arr_q[i];
                wt = ta - 16'(bur_q[i]);
            end
            return pack_word(K_RUN, id_q[i], st, len, dn, ta, wt);
        endfunction

        function int lowest(int key);
            int best;
            int bv;
            int v;
            best = -1;
            bv = 0;
            for (int i = 0; i < count; i++) begin
                if (!ready_at(i)) continue;
                v = key == 0 ? pri_q[i] : key == 1 ? bur_q[i] : rem_q[i];
                if (best < 0 || v < bv) begin
                    best = i;
                    bv = v;
                end
            end
            return best;
        endfunction

        function int sweep_next();
            for (int i = sweep; i < count; i++)
                if (ready_at(i)) return i;
            return -1;
        endfunction

        function t_out_word idle_tick();
            t_out_word w;
            w = pack_word(K_IDLE, 0, clock_now, 1, 0, 0, 0);
            clock_now = clock_now + 16'd1;
            return w;
        endfunction

        function t_out_word step();
            bit any;
            int c;
            logic [11:0] q;
            any = 0;
            for (int i = 0; i < count; i++)
                if (!fin_q[i]) any = 1;
            if (!any) return pack_word(K_DONE, 0, clock_now, 0, 0, 0, 0);
            if (mode == M_PRIO || mode == M_SJF) begin
                c = lowest(mode == M_PRIO ? 0 : 1);
                if (c < 0) return idle_tick();
                return run_for(c, rem_q[c]);
            end else if (mode == M_PPRI) begin
                t_out_word w;
                if (run_ok && (run_at >= count || fin_q[run_at])) run_ok = 0;
                c = lowest(0);
                if (c < 0 && !run_ok) return idle_tick();
                if (c >= 0 && (!run_ok || pri_q[c] < pri_q[run_at])) begin
                    run_at = c;
                    run_ok = 1;
                end
                w = run_for(run_at, 1);
                if (fin_q[run_at]) run_ok = 0;
                return w;
            end else if (mode == M_SRTF) begin
                c = lowest(2);
                if (c < 0) return idle_tick();
                return run_for(c, 1);
            end else begin
                t_out_word w;
                bit ran;
                q = quant == 0 ? 12'd1 : quant;
                c = sweep_next();
                if (c < 0) begin
                    ran = swept;
                    sweep = 0;
                    swept = 0;
                    if (ran) c = sweep_next();
                end
                if (c < 0) begin
                    sweep = 0;
                    swept = 0;
                    return idle_tick();
                end
                w = run_for(c, rem_q[c] < q ? rem_q[c] : q);
                sweep = c + 1;
                swept = 1;
                if (sweep >= count) begin
                    sweep = 0;
                    swept = 0;
                end
                return w;
            end
        endfunction

        function t_out_word load(t_in_word d);
            int pos;
            logic [11:0] b;
            if (count >= NJOB) return pack_word(K_FULL, d.job_id, 0, 0, 0, 0, 0);
            b = d.burst == 0 ? 12'd1 : d.burst;
            pos = count;
            if (mode != M_PPRI && mode != M_SRTF) begin
                for (int i = 0; i < count; i++) begin
                    if (arr_q[i] > d.arrival || (arr_q[i] == d.arrival && pri_q[i] > d.prio)) begin
                        pos = i;
                        break;
                    end
                end
            end
            for (int i = count; i > pos; i--) begin
                arr_q[i] = arr_q[i-1];
                bur_q[i] = bur_q[i-1];
                rem_q[i] = rem_q[i-1];
                pri_q[i] = pri_q[i-1];
                id_q[i] = id_q[i-1];
                fin_q[i] = fin_q[i-1];
            end
            if (run_ok && run_at >= pos && run_at < count) run_at++;
            arr_q[pos] = d.arrival;
            bur_q[pos] = b;
            rem_q[pos] = b;
            pri_q[pos] = d.prio;
            id_q[pos] = d.job_id;
            fin_q[pos] = 0;
            count++;
            return pack_word(K_LDOK, d.job_id, 0, 0, 0, 0, 0);
        endfunction

        function void note_input(t_in_word d);
            if (d.op == OP_LOAD) pending.push_back(load(d));
            else if (d.op == OP_STEP) pending.push_back(step());
            else if (d.op == OP_CLEAR) clear_all();
        endfunction

        function void check_result(t_out_word g);
            t_out_word e;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", g);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (g.kind !== e.kind) begin
                $error("kind exp %0d got %0d", e.kind, g.kind); errors++;
            end
            if (g.run_id !== e.run_id) begin
                $error("run_id exp %0d got %0d", e.run_id, g.run_id); errors++;
            end
            if (g.start_time !== e.start_time) begin
                $error("start_time exp %0d got %0d", e.start_time, g.start_time); errors++;
            end
            if (g.run_length !== e.run_length) begin
                $error("run_length exp %0d got %0d", e.run_length, g.run_length); errors++;
            end
            if (g.job_done !== e.job_done) begin
                $error("job_done exp %0d got %0d", e.job_done, g.job_done); errors++;
            end
            if (g.turnaround !== e.turnaround) begin
                $error("turnaround exp %0d got %0d", e.turnaround, g.turnaround); errors++;
            end
            if (g.waiting !== e.waiting) begin
                $error("waiting exp %0d got %0d", e.waiting, g.waiting); errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [11:0] cfg_data;

    sched_board board;
    int         burst_left;
    int         stall_mode;

    process_dispatch_scheduler_core uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall),
        .i_data(in_data),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_data(out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("process_dispatch_scheduler_core test failed");
        $finish;
    end

    // receiver stall pattern and result check
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 0;
        end else begin
            case (stall_mode)
                0: out_stall <= 0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 6);
            endcase
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        end
    end

    // valid stays high between words of one burst
    task automatic send_word(t_in_word d);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_data <= d;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        board.note_input(d);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        burst_left = 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_MODE) board.mode = val[2:0];
        else board.quant = val;
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    function automatic t_in_word job(logic [7:0] id, logic [15:0] a, logic [11:0] b,
                                     logic [7:0] p);
        t_in_word d;
        d.op = OP_LOAD;
        d.job_id = id;
        d.arrival = a;
        d.burst = b;
        d.prio = p;
        return d;
    endfunction

    function automatic t_in_word ctl(logic [1:0] op);
        t_in_word d;
        d = t_in_word'(IW'({$urandom, $urandom}));
        d.op = op;
        return d;
    endfunction

    task automatic random_set(int njobs, int nsteps);
        t_in_word d;
        send_word(ctl(OP_CLEAR));
        for (int j = 0; j < njobs; j++) begin
            d = job(8'($urandom), 16'($urandom_range(0, 40)),
                    12'($urandom_range(0, 12)), 8'($urandom_range(0, 7)));
            if ($urandom_range(0, 15) == 0) d.arrival = 16'($urandom);
            if ($urandom_range(0, 15) == 0) d.burst = 12'($urandom);
            if ($urandom_range(0, 7) == 0) d.prio = 8'($urandom);
            send_word(d);
        end
        for (int s = 0; s < nsteps; s++)
            send_word($urandom_range(0, 19) == 0 ? ctl(OP_NONE) : ctl(OP_STEP));
    endtask

    initial begin
        board = new();
        board.clear_all();
        board.mode = M_RR;
        board.quant = 12'd4;
        board.errors = 0;
        burst_left = 0;
        stall_mode = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = REG_MODE;
        cfg_data = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty dispatch, extremes, full table, wrap
        send_word(ctl(OP_STEP));
        send_word(job(8'hff, 16'hffff, 12'hfff, 8'hff));
        send_word(job(8'h00, 16'h0000, 12'h000, 8'h00));
        send_word(ctl(OP_STEP));
        send_word(ctl(OP_STEP));
        send_word(ctl(OP_NONE));
        send_word(ctl(OP_CLEAR));
        for (int j = 0; j < 17; j++) send_word(job(8'(j), 16'(j), 12'd1, 8'(16 - j)));
        send_word(ctl(OP_STEP));
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            write_reg(REG_MODE, 12'(ph < 8 ? ph : $urandom_range(0, 7)));
            write_reg(REG_QUANTUM, ph == 2 ? 12'hfff : ph == 3 ? 12'd0 :
                      ph == 4 ? 12'd1 : 12'($urandom_range(1, 6)));
            stall_mode = ph % 3;
            random_set($urandom_range(1, 10), $urandom_range(15, 30));
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("process_dispatch_scheduler_core test passed");
        else
            $display("process_dispatch_scheduler_core test failed");
        $finish;
    end
endmodule
